// ----- rtl/rar_pkg.sv -----
// rar_pkg: shared types and constants of the reorder ack receiver
// no dependencies
`default_nettype none
package rar_pkg;

   localparam int WINDOW_DEFAULT      = 16;
   localparam int PAYLOAD_MAX_DEFAULT = 121;

   localparam int SEQ_W     = 32;
   localparam int SIZE_W    = 7;
   localparam int CK_W      = 16;
   localparam int SUM_W     = 15;
   localparam int SLOT_W    = 4;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_DEL,
      ST_ACK,
      ST_DST,
      ST_OLD
   } state_type;

   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_DELIVER = 1'b1;

endpackage
`default_nettype wire

// ----- rtl/rar_ram.sv -----
// rar_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module rar_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/rar_mod_unit.sv -----
// rar_mod_unit: slot of a sequence number ahead of the expected one, one compare and
// subtract per cycle on the expected slot plus the distance
// depends on rar_pkg
`default_nettype none
module rar_mod_unit #(
   parameter int WINDOW = rar_pkg::WINDOW_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [$clog2(WINDOW)-1:0]   base,
   input  wire logic [$clog2(WINDOW)-1:0]   offset,
   input  wire logic                        wrap,
   output logic                             done,
   output logic [$clog2(WINDOW)-1:0]        remainder
);
   import rar_pkg::*;

   localparam int     SW       = $clog2(WINDOW);
   localparam int     RW       = SW + 2;
   // minus 2^32 mod window, folded back as an addend when the sequence number wraps
   localparam longint SEQ_SPAN = longint'(1) << SEQ_W;
   localparam int     WRAP_ADD = int'((WINDOW - SEQ_SPAN % WINDOW) % WINDOW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [RW-1:0] start_sum;

   assign start_sum = RW'(base) + RW'(offset) + (wrap ? RW'(WRAP_ADD) : '0);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = start_sum;
      end else if (busy_ff) begin
         if (rem_ff >= RW'(WINDOW)) begin
            rem_in = rem_ff - RW'(WINDOW);
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[SW-1:0];

endmodule
`default_nettype wire

// ----- rtl/reorder_ack_receiver.sv -----
// reorder_ack_receiver: selective repeat receiver, sequencer and slot store
// depends on rar_pkg, rar_mod_unit, rar_ram
// an in-order or older item moves the sequencer to ST_DEL or ST_OLD, and its first result is then
// registered into the output register once the output can take it; a new item is taken only in
// ST_IDLE, after the last result of the previous item has been emitted or its slot stored
// reset clears the expected number and all slot valid bits at once
`default_nettype none
module reorder_ack_receiver #(
   parameter int WINDOW      = rar_pkg::WINDOW_DEFAULT,
   parameter int PAYLOAD_MAX = rar_pkg::PAYLOAD_MAX_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // pkt_seq, pkt_size, pkt_checksum, payload_sum, zero pad
   input  wire logic [rar_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // seq_number, from_store, slot, deliver_size, zero pad
   output logic      [rar_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // kind
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast
);
   import rar_pkg::*;

   localparam int SW = $clog2(WINDOW);

   state_type         state_ff, state_in;
   logic [SEQ_W-1:0]  exp_ff, exp_in;
   logic [SW-1:0]     exp_slot_ff, exp_slot_in;
   logic [SW-1:0]     cnt_ff, cnt_in;
   logic [WINDOW-1:0] valid_ff, valid_in;
   logic [SEQ_W-1:0]  cur_seq_ff;
   logic [SIZE_W-1:0] cur_size_ff;

   logic              out_valid_ff, out_valid_in;
   logic              out_kind_ff, out_kind_in;
   logic [SEQ_W-1:0]  out_seq_ff, out_seq_in;
   logic              out_store_ff, out_store_in;
   logic [SLOT_W-1:0] out_slot_ff, out_slot_in;
   logic [SIZE_W-1:0] out_size_ff, out_size_in;
   logic              out_last_ff, out_last_in;

   logic [SEQ_W-1:0]  in_seq;
   logic [SIZE_W-1:0] in_size;
   logic [CK_W-1:0]   in_ck;
   logic [SUM_W-1:0]  in_sum;
   logic [SEQ_W-1:0]  diff;
   logic              seq_wrap;
   logic              accept, pass, is_del, is_store, is_old;
   logic              can_emit, emit, cont;
   logic [SW-1:0]     nxt_slot;

   logic              mod_start, mod_done;
   logic [SW-1:0]     mod_rem;
   logic              ram_wr, ram_rd;
   logic [SW-1:0]     ram_rd_addr;
   logic [SIZE_W-1:0] ram_rd_data;

   assign in_seq  = req_tdata[31:0];
   assign in_size = req_tdata[38:32];
   assign in_ck   = req_tdata[54:39];
   assign in_sum  = req_tdata[69:55];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign pass       = !in_sum[SUM_W-1] && ({1'b0, in_sum} == in_ck);
   assign diff       = in_seq - exp_ff;
   assign seq_wrap   = (in_seq < exp_ff);
   assign is_del     = (diff == '0);
   assign is_store   = !is_del && (diff < SEQ_W'(WINDOW));
   assign is_old     = diff[SEQ_W-1];

   assign can_emit = !out_valid_ff || rsp_tready;
   assign nxt_slot = (exp_ff == '1) ? '0 :
                     (exp_slot_ff == SW'(WINDOW-1)) ? '0 : exp_slot_ff + 1'b1;
   assign cont     = (cnt_ff != SW'(WINDOW-1)) && valid_ff[nxt_slot];

   assign mod_start = accept && pass && is_store;

   rar_mod_unit #(
      .WINDOW (WINDOW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .base      (exp_slot_ff),
      .offset    (diff[SW-1:0]),
      .wrap      (seq_wrap),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   rar_ram #(
      .WIDTH (SIZE_W),
      .DEPTH (WINDOW)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (mod_rem),
      .wr_data (cur_size_ff),
      .rd_en   (ram_rd),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   function automatic logic [SIZE_W-1:0] clamp(input logic [SIZE_W-1:0] s);
      return (s > SIZE_W'(PAYLOAD_MAX)) ? SIZE_W'(PAYLOAD_MAX) : s;
   endfunction

   always_comb begin
      state_in     = state_ff;
      exp_in       = exp_ff;
      exp_slot_in  = exp_slot_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      emit         = 1'b0;
      out_kind_in  = out_kind_ff;
      out_seq_in   = out_seq_ff;
      out_store_in = out_store_ff;
      out_slot_in  = out_slot_ff;
      out_size_in  = out_size_ff;
      out_last_in  = out_last_ff;
      ram_wr       = 1'b0;
      ram_rd       = 1'b0;
      ram_rd_addr  = nxt_slot;
      case (state_ff)
         ST_IDLE: begin
            if (accept && pass) begin
               if (is_del) begin
                  state_in = ST_DEL;
                  cnt_in   = '0;
               end else if (is_store) begin
                  state_in = ST_MOD;
               end else if (is_old) begin
                  state_in = ST_OLD;
               end
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               if (!valid_ff[mod_rem]) begin
                  valid_in[mod_rem] = 1'b1;
                  ram_wr            = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_DEL: begin
            if (can_emit) begin
               emit         = 1'b1;
               out_kind_in  = KIND_DELIVER;
               out_seq_in   = exp_ff;
               out_store_in = 1'b0;
               out_slot_in  = SLOT_W'(exp_slot_ff);
               out_size_in  = clamp(cur_size_ff);
               out_last_in  = 1'b0;
               state_in     = ST_ACK;
            end
         end
         ST_ACK: begin
            if (can_emit) begin
               emit         = 1'b1;
               out_kind_in  = KIND_ACK;
               out_seq_in   = exp_ff;
               out_store_in = 1'b0;
               out_slot_in  = '0;
               out_size_in  = '0;
               out_last_in  = !cont;
               exp_in       = exp_ff + 1'b1;
               exp_slot_in  = nxt_slot;
               if (cont) begin
                  ram_rd   = 1'b1;
                  state_in = ST_DST;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DST: begin
            if (can_emit) begin
               emit                  = 1'b1;
               out_kind_in           = KIND_DELIVER;
               out_seq_in            = exp_ff;
               out_store_in          = 1'b1;
               out_slot_in           = SLOT_W'(exp_slot_ff);
               out_size_in           = clamp(ram_rd_data);
               out_last_in           = 1'b0;
               valid_in[exp_slot_ff] = 1'b0;
               cnt_in                = cnt_ff + 1'b1;
               state_in              = ST_ACK;
            end
         end
         ST_OLD: begin
            if (can_emit) begin
               emit         = 1'b1;
               out_kind_in  = KIND_ACK;
               out_seq_in   = cur_seq_ff;
               out_store_in = 1'b0;
               out_slot_in  = '0;
               out_size_in  = '0;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      out_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         exp_ff       <= '0;
         exp_slot_ff  <= '0;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         exp_ff       <= exp_in;
         exp_slot_ff  <= exp_slot_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (accept) begin
         cur_seq_ff  <= in_seq;
         cur_size_ff <= in_size;
      end
      out_kind_ff  <= out_kind_in;
      out_seq_ff   <= out_seq_in;
      out_store_ff <= out_store_in;
      out_slot_ff  <= out_slot_in;
      out_size_ff  <= out_size_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {4'b0000, out_size_ff, out_slot_ff, out_store_ff, out_seq_ff};

endmodule
`default_nettype wire

// ----- verif/reorder_ack_receiver_tb.sv -----
// reorder_ack_receiver_tb: self-checking bench for the selective repeat receiver
// predicts deliveries and acks per packet item and checks them in order
// depends on rar_pkg and reorder_ack_receiver
`timescale 1ns / 1ps
module reorder_ack_receiver_tb;
   import rar_pkg::*;

   localparam int WIN      = WINDOW_DEFAULT;
   localparam int SIZE_CAP = PAYLOAD_MAX_DEFAULT;

   typedef struct packed {
      logic              kind;
      logic [SEQ_W-1:0]  seq_number;
      logic              from_store;
      logic [SLOT_W-1:0] slot;
      logic [SIZE_W-1:0] deliver_size;
      logic              last;
   } result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   result_type       expected_results[$];
   result_type       staged;
   bit               staged_ok = 0;
   logic [SEQ_W-1:0] next_seq = '0;
   logic             held_valid[WIN];
   logic [SIZE_W-1:0] held_size[WIN];
   int               errors = 0;
   bit               quiet = 0;
   int               hold_cycles = 0;

   reorder_ack_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] sz);
      return (sz > SIZE_CAP) ? SIZE_W'(SIZE_CAP) : sz;
   endfunction

   function automatic void stage_result(input logic kind, input logic [SEQ_W-1:0] seq,
                                        input logic fs, input logic [SLOT_W-1:0] sl,
                                        input logic [SIZE_W-1:0] sz);
      if (staged_ok)
         expected_results.push_back(staged);
      staged = '{kind, seq, fs, sl, sz, 1'b0};
      staged_ok = 1;
   endfunction

   function automatic void predict_packet(input logic [SEQ_W-1:0] seq,
                                          input logic [SIZE_W-1:0] sz,
                                          input logic [CK_W-1:0] ck,
                                          input logic [SUM_W-1:0] sum);
      logic [SEQ_W-1:0]  delta;
      logic [SLOT_W-1:0] s;
      int                k;
      if (sum[SUM_W-1] || {1'b0, sum} != ck)
         return;
      delta = seq - next_seq;
      if (delta == 0) begin
         stage_result(KIND_DELIVER, seq, 1'b0, SLOT_W'(seq % WIN), clamp_size(sz));
         stage_result(KIND_ACK, seq, 1'b0, '0, '0);
         next_seq = next_seq + 1;
         for (k = 0; k < WIN - 1; k++) begin
            s = SLOT_W'(next_seq % WIN);
            if (!held_valid[s])
               break;
            stage_result(KIND_DELIVER, next_seq, 1'b1, s, clamp_size(held_size[s]));
            stage_result(KIND_ACK, next_seq, 1'b0, '0, '0);
            held_valid[s] = 1'b0;
            next_seq = next_seq + 1;
         end
      end else if (delta < WIN) begin
         s = SLOT_W'(seq % WIN);
         if (!held_valid[s]) begin
            held_valid[s] = 1'b1;
            held_size[s] = sz;
         end
         return;
      end else if (delta[SEQ_W-1]) begin
         stage_result(KIND_ACK, seq, 1'b0, '0, '0);
      end else begin
         return;
      end
      staged.last = 1'b1;
      expected_results.push_back(staged);
      staged_ok = 0;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic [SIZE_W-1:0] sz,
                              input logic [CK_W-1:0] ck, input logic [SUM_W-1:0] sum);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, sum, ck, sz, seq};
      do @(posedge clock); while (!req_tready);
      predict_packet(seq, sz, ck, sum);
   endtask

   task automatic send_random(input int well_pct);
      logic [SEQ_W-1:0]  seq;
      logic [CK_W-1:0]   ck;
      logic [SUM_W-1:0]  sum;
      int                r;
      r = $urandom_range(0, 99);
      if (r < well_pct)
         seq = ($urandom_range(0, 3) == 0) ? next_seq : next_seq + $urandom_range(0, WIN);
      else if (r < well_pct + (100 - well_pct) / 2)
         seq = next_seq - $urandom_range(1, 40);
      else
         seq = $urandom;
      if ($urandom_range(0, 9) != 0) begin
         sum = SUM_W'($urandom_range(0, 16383));
         ck  = {1'b0, sum};
      end else begin
         sum = SUM_W'($urandom);
         ck  = CK_W'($urandom);
      end
      send_packet(seq, SIZE_W'($urandom_range(0, 127)), ck, sum);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic check_result();
      result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch($sformatf("unexpected result seq %0h", rsp_tdata[31:0]));
         return;
      end
      want = expected_results.pop_front();
      if (rsp_tuser !== want.kind)
         report_mismatch($sformatf("kind %b want %b", rsp_tuser, want.kind));
      if (rsp_tdata[31:0] !== want.seq_number)
         report_mismatch($sformatf("seq %0h want %0h", rsp_tdata[31:0], want.seq_number));
      if (rsp_tdata[32] !== want.from_store)
         report_mismatch($sformatf("from_store %b want %b", rsp_tdata[32], want.from_store));
      if (rsp_tdata[36:33] !== want.slot)
         report_mismatch($sformatf("slot %0d want %0d", rsp_tdata[36:33], want.slot));
      if (rsp_tdata[43:37] !== want.deliver_size)
         report_mismatch($sformatf("size %0d want %0d", rsp_tdata[43:37], want.deliver_size));
      if (rsp_tlast !== want.last)
         report_mismatch($sformatf("last %b want %b", rsp_tlast, want.last));
      if (rsp_tdata[47:44] !== 4'b0000)
         report_mismatch("nonzero pad bits");
   endtask

   initial begin : rsp_side
      int stall;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            stall = hold_cycles;
            hold_cycles = 0;
         end else begin
            stall = quiet ? 0 : $urandom_range(0, 15);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         check_result();
      end
   end

   task automatic test_directed();
      logic [SEQ_W-1:0] base;
      int               i;
      send_packet(32'd0, 7'd10, 16'd5, 15'd5);
      send_packet(32'd1, 7'd10, 16'hFFFF, 15'h7FFF);
      send_packet(32'd1, 7'd10, 16'h4005, 15'h4005);
      send_packet(32'd3, 7'd127, 16'd0, 15'd0);
      send_packet(32'd3, 7'd20, 16'd7, 15'd7);
      send_packet(32'd2, 7'd0, 16'd9, 15'd9);
      send_packet(32'd1, 7'd121, 16'h3FFF, 15'h3FFF);
      send_packet(32'd0, 7'd5, 16'd1, 15'd1);
      send_packet(32'hFFFF_FFFF, 7'd5, 16'd2, 15'd2);
      send_packet(next_seq + WIN, 7'd5, 16'd3, 15'd3);
      send_packet(next_seq + 32'h7FFF_FFFF, 7'd5, 16'd4, 15'd4);
      send_packet(next_seq + 32'h8000_0000, 7'd5, 16'd6, 15'd6);
      // fill every slot ahead, then the missing one drains them all
      base = next_seq;
      for (i = 1; i < WIN; i++)
         send_packet(base + i, 7'(i * 8 + 1), 16'(i * 100), 15'(i * 100));
      send_packet(base, 7'd122, 16'd11, 15'd11);
      wait_drained();
   endtask

   task automatic test_random_traffic(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         if (i % 40 == 0)
            quiet = ($urandom_range(0, 2) == 0);
         send_random(80);
      end
      quiet = 0;
   endtask

   task automatic test_output_backpressure();
      int i;
      hold_cycles = 400;
      quiet = 1;
      for (i = 0; i < 30; i++)
         send_random(95);
      quiet = 0;
   endtask

   task automatic test_sender_pause();
      int i;
      wait_drained();
      for (i = 0; i < 5; i++)
         send_random(90);
   endtask

   initial begin
      for (int j = 0; j < WIN; j++) begin
         held_valid[j] = 1'b0;
         held_size[j]  = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_traffic(245);
      test_output_backpressure();
      test_sender_pause();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("expected results left over");
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/rar_pkg.sv
rtl/rar_ram.sv
rtl/rar_mod_unit.sv
rtl/reorder_ack_receiver.sv
verif/reorder_ack_receiver_tb.sv
